// ===== rtl/brightness_alpha_interpolator_defines.svh =====
`ifndef BRIGHTNESS_ALPHA_INTERPOLATOR_DEFINES_SVH
`define BRIGHTNESS_ALPHA_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication check, held off while reset is low
`define BAI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bai: same-cycle check failed");

// Next-cycle implication check, held off while reset is low
`define BAI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bai: next-cycle check failed");

`endif

// ===== rtl/bai_pkg.sv =====
`default_nettype none

package bai_pkg;

  // Field widths
  localparam int unsigned LVL_W    = 12;
  localparam int unsigned ALP_W    = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFGIDX_W = 2;
  localparam int unsigned USED_W   = 6;

  // Shared multiply / divide unit
  localparam int unsigned MUL_A_W   = 8;
  localparam int unsigned MUL_B_W   = 12;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned QUOT_W    = 8;

  // Built-in table
  localparam int unsigned DFLT_COUNT = 23;
  localparam int unsigned DFLT_IDX_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_SCALE = 2'd2
  } bai_kind_e;

  typedef enum logic [CFGIDX_W-1:0] {
    CFG_OVERRIDE  = 2'd0,
    CFG_ENTRIES   = 2'd1,
    CFG_SCALE_MAX = 2'd2
  } bai_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MULDIV,
    ST_RESULT
  } bai_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } bai_md_state_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_B_W-1:0] divisor;
  } bai_md_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } bai_md_rsp_t;

  // Built-in breakpoints: {level, alpha}; beyond the last entry reads zero
  function automatic logic [LVL_W+ALP_W-1:0] bai_dflt_entry(input logic [DFLT_IDX_W-1:0] idx);
    logic [LVL_W+ALP_W-1:0] e;
    begin
      case (idx)
        5'd0:    e = {12'd0,   8'hff};
        5'd1:    e = {12'd1,   8'hfc};
        5'd2:    e = {12'd2,   8'hfb};
        5'd3:    e = {12'd3,   8'hfa};
        5'd4:    e = {12'd4,   8'hf9};
        5'd5:    e = {12'd5,   8'hf8};
        5'd6:    e = {12'd6,   8'hf7};
        5'd7:    e = {12'd8,   8'hf6};
        5'd8:    e = {12'd10,  8'hf4};
        5'd9:    e = {12'd15,  8'hf0};
        5'd10:   e = {12'd20,  8'hea};
        5'd11:   e = {12'd30,  8'he0};
        5'd12:   e = {12'd45,  8'hd0};
        5'd13:   e = {12'd70,  8'hbc};
        5'd14:   e = {12'd100, 8'h98};
        5'd15:   e = {12'd120, 8'h80};
        5'd16:   e = {12'd140, 8'h70};
        5'd17:   e = {12'd160, 8'h58};
        5'd18:   e = {12'd180, 8'h48};
        5'd19:   e = {12'd200, 8'h30};
        5'd20:   e = {12'd220, 8'h20};
        5'd21:   e = {12'd240, 8'h10};
        5'd22:   e = {12'd260, 8'h00};
        default: e = '0;
      endcase
      return e;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bai_table.sv =====
`default_nettype none

module bai_table import bai_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned AW = $clog2(TABLE_DEPTH),
  parameter int unsigned CW = ($clog2(TABLE_DEPTH + 1) > DFLT_IDX_W) ?
                              $clog2(TABLE_DEPTH + 1) : DFLT_IDX_W
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [LVL_W-1:0] wlvl_i,
  input  wire logic [ALP_W-1:0] walp_i,
  input  wire logic [CW-1:0]    raddr_i,
  input  wire logic             dflt_i,
  output logic      [LVL_W-1:0] rd_lvl_o,
  output logic      [ALP_W-1:0] rd_alp_o
);

  logic [LVL_W-1:0] lvl_mem [TABLE_DEPTH];
  logic [ALP_W-1:0] alp_mem [TABLE_DEPTH];

  logic [LVL_W-1:0] mem_lvl_q;
  logic [ALP_W-1:0] mem_alp_q;
  logic [LVL_W+ALP_W-1:0] dflt_q;
  logic             sel_dflt_q;

  // Loaded table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      lvl_mem[waddr_i] <= wlvl_i;
      alp_mem[waddr_i] <= walp_i;
    end
    mem_lvl_q <= lvl_mem[raddr_i[AW-1:0]];
    mem_alp_q <= alp_mem[raddr_i[AW-1:0]];
  end

  // Built-in table read, registered alongside
  always_ff @(posedge clk_i) begin
    dflt_q     <= bai_dflt_entry(raddr_i[DFLT_IDX_W-1:0]);
    sel_dflt_q <= dflt_i;
  end

  assign rd_lvl_o = sel_dflt_q ? dflt_q[LVL_W+ALP_W-1:ALP_W] : mem_lvl_q;
  assign rd_alp_o = sel_dflt_q ? dflt_q[ALP_W-1:0] : mem_alp_q;

endmodule

`default_nettype wire

// ===== rtl/bai_muldiv.sv =====
`default_nettype none

module bai_muldiv import bai_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bai_md_req_t req_i,
  output bai_md_rsp_t      rsp_o
);

  bai_md_state_e state_q, state_d;

  logic [MUL_A_W-1:0] a_q, a_d;
  logic [MUL_B_W-1:0] b_q, b_d;
  logic [MUL_B_W-1:0] dvs_q, dvs_d;
  logic [PROD_W-1:0]  dvd_q, dvd_d;
  logic [MUL_B_W:0]   rem_q, rem_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;

  logic [MUL_B_W:0]   rem_sh;
  logic               fits;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Operands and shift registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  // One restoring division step: shift in a dividend bit, subtract if it fits
  assign rem_sh = {rem_q[MUL_B_W-1:0], dvd_q[PROD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    dvs_d   = dvs_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.mul_a;
          b_d     = req_i.mul_b;
          dvs_d   = req_i.divisor;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        dvd_d   = PROD_W'(a_q) * PROD_W'(b_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = MD_DIV;
      end
      MD_DIV: begin
        rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        dvd_d = {dvd_q[PROD_W-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = MD_DONE;
        end
      end
      MD_DONE: begin
        state_d = MD_IDLE;
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  assign rsp_o.done = (state_q == MD_DONE);
  assign rsp_o.quot = dvd_q[QUOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/brightness_alpha_interpolator.sv =====
// Load item: taken with no result; the input stays ready.
// Query: one table entry compared per cycle (up to 32 loaded or 23 built-in), then
//   the shared multiply/divide unit when interpolating, then the result register.
// Scale item: scaled bytes go through the same unit; pass-through and clamped bytes skip it.
// One item in flight; the result register lets the next item enter while it waits.
// Reset (async, low): control and config registers to 0 except scale_max to 255; payload registers and table undefined.
`default_nettype none

`include "brightness_alpha_interpolator_defines.svh"

module brightness_alpha_interpolator import bai_pkg::*; #(
  parameter int unsigned TABLE_DEPTH    = 32,
  parameter int unsigned SCALED_CMD_LEN = 22
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CFGIDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  // input items
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [IDX_W-1:0]    entry_index_i,
  input  wire logic [LVL_W-1:0]    entry_brightness_i,
  input  wire logic [ALP_W-1:0]    entry_alpha_i,
  input  wire logic [LVL_W-1:0]    level_i,
  input  wire logic [BYTE_W-1:0]   cmd_byte_i,
  input  wire logic [POS_W-1:0]    byte_position_i,
  input  wire logic [POS_W-1:0]    cmd_length_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [BYTE_W-1:0]   value_o,
  output logic                     clamped_o
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = ($clog2(TABLE_DEPTH + 1) > DFLT_IDX_W) ?
                                  $clog2(TABLE_DEPTH + 1) : DFLT_IDX_W;
  localparam int unsigned CMP_W = (CW > USED_W) ? CW : USED_W;

  // Configuration registers
  logic [ALP_W-1:0]  override_q;
  logic [USED_W-1:0] used_q;
  logic [CFG_W-1:0]  scale_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      override_q  <= '0;
      used_q      <= '0;
      scale_max_q <= CFG_W'(255);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OVERRIDE:  override_q  <= cfg_data_i[ALP_W-1:0];
        CFG_ENTRIES:   used_q      <= cfg_data_i[USED_W-1:0];
        CFG_SCALE_MAX: scale_max_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Table selection and entry count
  logic          dflt;
  logic [CW-1:0] cnt;

  assign dflt = (used_q == '0);
  always_comb begin
    if (dflt) begin
      cnt = CW'(DFLT_COUNT);
    end else if (CMP_W'(used_q) > CMP_W'(TABLE_DEPTH)) begin
      cnt = CW'(TABLE_DEPTH);
    end else begin
      cnt = CW'(used_q);
    end
  end

  // Sequencer state and working registers
  bai_state_e state_q, state_d;

  logic [CW-1:0]     idx_q, idx_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [LVL_W-1:0]  prev_lvl_q, prev_lvl_d;
  logic [ALP_W-1:0]  prev_alp_q, prev_alp_d;
  logic [ALP_W-1:0]  ya_q, ya_d;
  logic              neg_q, neg_d;
  logic              is_query_q, is_query_d;
  logic [BYTE_W-1:0] res_value_q, res_value_d;
  logic              res_clamped_q, res_clamped_d;
  logic [ALP_W-1:0]  last_alpha_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_value_q;
  logic              out_clamped_q;

  logic              accept;
  logic              tbl_we;
  logic [CW-1:0]     rd_addr;
  logic [LVL_W-1:0]  ent_lvl;
  logic [ALP_W-1:0]  ent_alp;
  logic [CFG_W-1:0]  full;
  logic              scaled;
  logic [ALP_W:0]    sum9;
  bai_md_req_t       md_req;
  bai_md_rsp_t       md_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tbl_we     = accept && (kind_i == KIND_LOAD) &&
                      (CW'(entry_index_i) < CW'(TABLE_DEPTH));

  // Next entry is fetched while the current one is compared
  assign rd_addr = (state_q == ST_SEARCH) ? (idx_q + 1'b1) : '0;

  bai_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (tbl_we),
    .waddr_i  (AW'(entry_index_i)),
    .wlvl_i   (entry_brightness_i),
    .walp_i   (entry_alpha_i),
    .raddr_i  (rd_addr),
    .dflt_i   (dflt),
    .rd_lvl_o (ent_lvl),
    .rd_alp_o (ent_alp)
  );

  bai_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Scale item decode
  assign full   = (scale_max_q == '0) ? CFG_W'(1) : scale_max_q;
  assign scaled = (cmd_length_i == POS_W'(SCALED_CMD_LEN)) && (byte_position_i != '0) &&
                  (byte_position_i < cmd_length_i);
  assign sum9   = {1'b0, ya_q} + {1'b0, md_rsp.quot};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      last_alpha_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RESULT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_RESULT && is_query_q) begin
        last_alpha_q <= res_value_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    level_q       <= level_d;
    prev_lvl_q    <= prev_lvl_d;
    prev_alp_q    <= prev_alp_d;
    ya_q          <= ya_d;
    neg_q         <= neg_d;
    is_query_q    <= is_query_d;
    res_value_q   <= res_value_d;
    res_clamped_q <= res_clamped_d;
    if (state_q == ST_RESULT && (!out_valid_q || out_ready_i)) begin
      out_value_q   <= res_value_q;
      out_clamped_q <= res_clamped_q;
    end
  end

  // Sequencer: next state and unit requests
  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    level_d        = level_q;
    prev_lvl_d     = prev_lvl_q;
    prev_alp_d     = prev_alp_q;
    ya_d           = ya_q;
    neg_d          = neg_q;
    is_query_d     = is_query_q;
    res_value_d    = res_value_q;
    res_clamped_d  = res_clamped_q;
    md_req.start   = 1'b0;
    md_req.mul_a   = '0;
    md_req.mul_b   = '0;
    md_req.divisor = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_QUERY: begin
              is_query_d    = 1'b1;
              level_d       = level_i;
              res_clamped_d = 1'b0;
              idx_d         = '0;
              if (override_q != '0) begin
                res_value_d = override_q;
                state_d     = ST_RESULT;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            KIND_SCALE: begin
              is_query_d = 1'b0;
              if (!scaled) begin
                res_value_d   = cmd_byte_i;
                res_clamped_d = 1'b0;
                state_d       = ST_RESULT;
              end else if (CFG_W'(last_alpha_q) > full) begin
                res_value_d   = '0;
                res_clamped_d = 1'b1;
                state_d       = ST_RESULT;
              end else begin
                res_clamped_d  = 1'b0;
                md_req.start   = 1'b1;
                md_req.mul_a   = cmd_byte_i;
                md_req.mul_b   = full - CFG_W'(last_alpha_q);
                md_req.divisor = full;
                state_d        = ST_MULDIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (ent_lvl >= level_q) begin
          if (idx_q == '0) begin
            res_value_d = ent_alp;
            state_d     = ST_RESULT;
          end else if (ent_lvl <= prev_lvl_q) begin
            res_value_d = prev_alp_q;
            state_d     = ST_RESULT;
          end else begin
            // interpolate on the magnitude of the alpha step, sign kept aside
            ya_d           = prev_alp_q;
            neg_d          = ent_alp < prev_alp_q;
            md_req.start   = 1'b1;
            md_req.mul_a   = (ent_alp < prev_alp_q) ? (prev_alp_q - ent_alp) :
                                                      (ent_alp - prev_alp_q);
            md_req.mul_b   = level_q - prev_lvl_q;
            md_req.divisor = ent_lvl - prev_lvl_q;
            state_d        = ST_MULDIV;
          end
        end else begin
          prev_lvl_d = ent_lvl;
          prev_alp_d = ent_alp;
          if (idx_q + 1'b1 == cnt) begin
            // past the last entry: clamp to its alpha
            res_value_d = ent_alp;
            state_d     = ST_RESULT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_MULDIV: begin
        if (md_rsp.done) begin
          if (!is_query_q) begin
            res_value_d = md_rsp.quot;
          end else if (neg_q) begin
            res_value_d = (md_rsp.quot > ya_q) ? '0 : (ya_q - md_rsp.quot);
          end else begin
            res_value_d = sum9[ALP_W] ? '1 : sum9[ALP_W-1:0];
          end
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign clamped_o   = out_clamped_q;

  // Checks
  `BAI_ASSERT_IMPL(a_clamp_zero, clk_i, rst_ni, out_valid_q && out_clamped_q, out_value_q == '0)
  `BAI_ASSERT_IMPL(a_md_done_state, clk_i, rst_ni, md_rsp.done, state_q == ST_MULDIV)
  `BAI_ASSERT_IMPL(a_idx_range, clk_i, rst_ni, state_q == ST_SEARCH, idx_q < cnt)
  `BAI_ASSERT_NEXT(a_last_alpha, clk_i, rst_ni, state_q == ST_RESULT && is_query_q, last_alpha_q == $past(res_value_q))

endmodule

`default_nettype wire

// ===== tb/tb_brightness_alpha_interpolator.sv =====
`timescale 1ns / 100ps

module tb_brightness_alpha_interpolator;
  import bai_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 32;
  localparam int unsigned SCALED_CMD_LEN = 22;
  localparam int unsigned DFLT_ENTRIES   = 23;
  localparam int unsigned MAX_IDLE       = 12;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned ITEM_TARGET    = 1500;
  localparam int unsigned PHASE_ITEMS    = 180;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  entry_index;
    logic [LVL_W-1:0]  entry_brightness;
    logic [ALP_W-1:0]  entry_alpha;
    logic [LVL_W-1:0]  level;
    logic [BYTE_W-1:0] cmd_byte;
    logic [POS_W-1:0]  byte_position;
    logic [POS_W-1:0]  cmd_length;
  } cmd_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              clamped;
  } alpha_result_t;

  // DUT connections, all inputs known from time zero
  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_we_i           = 1'b0;
  logic [CFGIDX_W-1:0] cfg_index_i        = '0;
  logic [CFG_W-1:0]    cfg_data_i         = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i             = '0;
  logic [IDX_W-1:0]    entry_index_i      = '0;
  logic [LVL_W-1:0]    entry_brightness_i = '0;
  logic [ALP_W-1:0]    entry_alpha_i      = '0;
  logic [LVL_W-1:0]    level_i            = '0;
  logic [BYTE_W-1:0]   cmd_byte_i         = '0;
  logic [POS_W-1:0]    byte_position_i    = '0;
  logic [POS_W-1:0]    cmd_length_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i        = 1'b0;
  logic [BYTE_W-1:0]   value_o;
  logic                clamped_o;

  brightness_alpha_interpolator #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .SCALED_CMD_LEN (SCALED_CMD_LEN)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .entry_index_i      (entry_index_i),
    .entry_brightness_i (entry_brightness_i),
    .entry_alpha_i      (entry_alpha_i),
    .level_i            (level_i),
    .cmd_byte_i         (cmd_byte_i),
    .byte_position_i    (byte_position_i),
    .cmd_length_i       (cmd_length_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .value_o            (value_o),
    .clamped_o          (clamped_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Built-in breakpoint curve
  logic [LVL_W-1:0] dflt_level [DFLT_ENTRIES] = '{
    0, 1, 2, 3, 4, 5, 6, 8, 10, 15, 20, 30, 45, 70, 100, 120, 140, 160,
    180, 200, 220, 240, 260
  };
  logic [ALP_W-1:0] dflt_alpha [DFLT_ENTRIES] = '{
    8'hff, 8'hfc, 8'hfb, 8'hfa, 8'hf9, 8'hf8, 8'hf7, 8'hf6, 8'hf4, 8'hf0,
    8'hea, 8'he0, 8'hd0, 8'hbc, 8'h98, 8'h80, 8'h70, 8'h58, 8'h48, 8'h30,
    8'h20, 8'h10, 8'h00
  };

  // Predicted block state
  logic [ALP_W-1:0]  pred_override     = '0;
  logic [USED_W-1:0] pred_entries_used = '0;
  logic [LVL_W-1:0]  pred_scale_max    = 12'd255;
  logic [ALP_W-1:0]  pred_last_alpha   = '0;
  logic [LVL_W-1:0]  bp_level_q [TABLE_DEPTH];
  logic [ALP_W-1:0]  bp_alpha_q [TABLE_DEPTH];

  alpha_result_t pending_results [$];
  alpha_result_t exp_result;

  bit tx_no_idle  = 1'b0;
  bit rx_no_idle  = 1'b0;
  bit rx_hold_req = 1'b0;

  int unsigned mismatches  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_loads     = 0;
  int unsigned n_queries   = 0;
  int unsigned n_scales    = 0;
  int unsigned n_clamped   = 0;
  int unsigned n_ignored   = 0;
  int unsigned n_settings  = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned entries_in_use();
    if (pred_entries_used == 0) return DFLT_ENTRIES;
    return (pred_entries_used > TABLE_DEPTH) ? TABLE_DEPTH : 32'(pred_entries_used);
  endfunction

  function automatic int unsigned bp_level(bit use_dflt, int unsigned i);
    return use_dflt ? 32'(dflt_level[i]) : 32'(bp_level_q[i]);
  endfunction

  function automatic int unsigned bp_alpha(bit use_dflt, int unsigned i);
    return use_dflt ? 32'(dflt_alpha[i]) : 32'(bp_alpha_q[i]);
  endfunction

  // Alpha for a brightness: first breakpoint at or above it, linear in between
  function automatic logic [ALP_W-1:0] interp_alpha(logic [LVL_W-1:0] lvl);
    bit          use_dflt;
    int unsigned count, i;
    int          xa, xb, ya, yb, r;
    if (pred_override != 0) return pred_override;
    use_dflt = (pred_entries_used == 0);
    count = entries_in_use();
    i = 0;
    while (i < count && bp_level(use_dflt, i) < lvl) i++;
    if (i == 0) return ALP_W'(bp_alpha(use_dflt, 0));
    if (i == count) return ALP_W'(bp_alpha(use_dflt, count - 1));
    xa = bp_level(use_dflt, i - 1);
    xb = bp_level(use_dflt, i);
    ya = bp_alpha(use_dflt, i - 1);
    yb = bp_alpha(use_dflt, i);
    if (xb <= xa) return ALP_W'(ya);
    // signed division truncates toward zero
    r = ya + ((yb - ya) * (int'(lvl) - xa)) / (xb - xa);
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[ALP_W-1:0];
  endfunction

  // Command byte: passed through, scaled by (full - alpha) / full, or zeroed when alpha exceeds full
  function automatic alpha_result_t scale_cmd_byte(cmd_item_t it);
    alpha_result_t res;
    int unsigned   full;
    full = (pred_scale_max == 0) ? 1 : 32'(pred_scale_max);
    res.value   = it.cmd_byte;
    res.clamped = 1'b0;
    if (it.cmd_length == SCALED_CMD_LEN && it.byte_position != 0 &&
        it.byte_position < it.cmd_length) begin
      if (pred_last_alpha > full) begin
        res.value   = '0;
        res.clamped = 1'b1;
      end else begin
        res.value = BYTE_W'((32'(it.cmd_byte) * (full - 32'(pred_last_alpha))) / full);
      end
    end
    return res;
  endfunction

  // Update predicted state for an accepted item and queue its result, if it has one
  task automatic record_accepted(cmd_item_t it);
    alpha_result_t res;
    case (it.kind)
      KIND_LOAD: begin
        bp_level_q[it.entry_index] = it.entry_brightness;
        bp_alpha_q[it.entry_index] = it.entry_alpha;
        n_loads++;
      end
      KIND_QUERY: begin
        pred_last_alpha = interp_alpha(it.level);
        res.value   = pred_last_alpha;
        res.clamped = 1'b0;
        pending_results.push_back(res);
        n_queries++;
      end
      KIND_SCALE: begin
        res = scale_cmd_byte(it);
        pending_results.push_back(res);
        n_scales++;
        if (res.clamped) n_clamped++;
      end
      default: n_ignored++;
    endcase
  endtask

  // Offer one item; valid stays up until the block takes it
  task automatic send_item(cmd_item_t it);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    kind_i             <= it.kind;
    entry_index_i      <= it.entry_index;
    entry_brightness_i <= it.entry_brightness;
    entry_alpha_i      <= it.entry_alpha;
    level_i            <= it.level;
    cmd_byte_i         <= it.cmd_byte;
    byte_position_i    <= it.byte_position;
    cmd_length_i       <= it.cmd_length;
    do @(posedge clk_i); while (!in_ready_o);
    record_accepted(it);
  endtask

  // Fields an item does not use still get random values
  function automatic cmd_item_t noise_item();
    cmd_item_t it;
    it.kind             = KIND_W'($urandom);
    it.entry_index      = IDX_W'($urandom);
    it.entry_brightness = LVL_W'($urandom);
    it.entry_alpha      = ALP_W'($urandom);
    it.level            = LVL_W'($urandom);
    it.cmd_byte         = BYTE_W'($urandom);
    it.byte_position    = POS_W'($urandom);
    it.cmd_length       = POS_W'($urandom);
    return it;
  endfunction

  task automatic send_load(logic [IDX_W-1:0] idx, logic [LVL_W-1:0] lvl,
                           logic [ALP_W-1:0] alp);
    cmd_item_t it;
    it = noise_item();
    it.kind             = KIND_LOAD;
    it.entry_index      = idx;
    it.entry_brightness = lvl;
    it.entry_alpha      = alp;
    send_item(it);
  endtask

  task automatic send_query(logic [LVL_W-1:0] lvl);
    cmd_item_t it;
    it = noise_item();
    it.kind  = KIND_QUERY;
    it.level = lvl;
    send_item(it);
  endtask

  task automatic send_scale(logic [BYTE_W-1:0] b, logic [POS_W-1:0] pos,
                            logic [POS_W-1:0] len);
    cmd_item_t it;
    it = noise_item();
    it.kind          = KIND_SCALE;
    it.cmd_byte      = b;
    it.byte_position = pos;
    it.cmd_length    = len;
    send_item(it);
  endtask

  task automatic send_unused();
    cmd_item_t it;
    it = noise_item();
    it.kind = KIND_UNUSED;
    send_item(it);
  endtask

  // Stop offering, let all results drain, then allow for items with no result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [ALP_W-1:0] ovr, logic [USED_W-1:0] used,
                            logic [LVL_W-1:0] smax);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_OVERRIDE;
    cfg_data_i  <= CFG_W'(ovr);
    @(posedge clk_i);
    cfg_index_i <= CFG_ENTRIES;
    cfg_data_i  <= CFG_W'(used);
    @(posedge clk_i);
    cfg_index_i <= CFG_SCALE_MAX;
    cfg_data_i  <= smax;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred_override     = ovr;
    pred_entries_used = used;
    pred_scale_max    = smax;
    n_settings++;
  endtask

  // Query levels around the breakpoints in use, with some anywhere
  function automatic logic [LVL_W-1:0] pick_level();
    bit          use_dflt;
    int unsigned count, lv;
    use_dflt = (pred_entries_used == 0);
    count = entries_in_use();
    case ($urandom_range(0, 3))
      0: lv = $urandom_range(0, 4095);
      1, 2: begin
        lv = bp_level(use_dflt, $urandom_range(0, count - 1)) + $urandom_range(0, 2);
        lv = (lv == 0) ? 0 : lv - 1;
      end
      default: lv = $urandom_range(0, bp_level(use_dflt, count - 1) + 40);
    endcase
    return (lv > 4095) ? 12'd4095 : lv[LVL_W-1:0];
  endfunction

  // Built-in curve, scaling rules and the ignored kind
  task automatic test_default_table();
    set_config(8'd0, 6'd0, 12'd255);
    send_scale(8'hff, 6'd1, POS_W'(SCALED_CMD_LEN));  // alpha still zero from reset
    send_query(12'd0);                         // exactly on first breakpoint
    send_query(12'd7);                         // negative slope truncates toward zero
    send_query(12'd100);
    send_scale(8'hff, 6'd21, POS_W'(SCALED_CMD_LEN));
    send_scale(8'h80, 6'd0, POS_W'(SCALED_CMD_LEN));   // byte 0 passes
    send_scale(8'h80, 6'd22, POS_W'(SCALED_CMD_LEN));  // position at length passes
    send_scale(8'hff, 6'd63, 6'd63);           // other lengths pass
    send_scale(8'h5a, 6'd5, 6'd21);
    send_unused();
    send_query(12'd261);                       // past last breakpoint
    send_query(12'd4095);
    send_scale(8'hff, 6'd10, POS_W'(SCALED_CMD_LEN));
  endtask

  // Override register and full-scale extremes
  task automatic test_override_and_full_scale();
    set_config(8'hff, 6'd0, 12'd1);
    send_query(12'd2000);
    send_scale(8'hc3, 6'd5, POS_W'(SCALED_CMD_LEN));   // alpha above full scale
    send_scale(8'hc3, 6'd0, POS_W'(SCALED_CMD_LEN));
    set_config(8'd1, 6'd0, 12'd0);             // zero full scale counts as one
    send_query(12'd0);
    send_scale(8'hff, 6'd1, POS_W'(SCALED_CMD_LEN));
    set_config(8'd0, 6'd0, 12'd4095);
    send_query(12'd100);
    send_scale(8'hff, 6'd21, POS_W'(SCALED_CMD_LEN));
  endtask

  // Small loaded table, deliberately out of order
  task automatic test_loaded_table();
    send_load(5'd0, 12'd100, 8'd200);
    send_load(5'd1, 12'd50, 8'd10);
    send_load(5'd2, 12'd4095, 8'd0);
    set_config(8'd0, 6'd3, 12'd255);
    send_query(12'd0);
    send_query(12'd101);
    send_query(12'd4095);
    send_scale(8'hff, 6'd2, POS_W'(SCALED_CMD_LEN));
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    int unsigned k;
    tx_no_idle  = 1'b1;
    rx_hold_req = 1'b1;
    for (k = 0; k < 40; k++) begin
      if (k[0]) send_query(pick_level());
      else send_scale(BYTE_W'($urandom), POS_W'($urandom_range(1, SCALED_CMD_LEN - 1)),
                      POS_W'(SCALED_CMD_LEN));
    end
    tx_no_idle = 1'b0;
  endtask

  // Random settings; mostly query-then-command sequences, some noise
  task automatic test_random_traffic();
    int unsigned phase, goal, size, j, lv, step_max, sel, blen, p;
    logic [ALP_W-1:0]  ovr;
    logic [USED_W-1:0] used;
    logic [LVL_W-1:0]  smax;
    bit ascending;
    phase = 0;
    while (n_loads + n_queries + n_scales < ITEM_TARGET) begin
      ovr = ($urandom_range(0, 3) == 0) ? ALP_W'($urandom_range(1, 255)) : 8'd0;
      case ($urandom_range(0, 5))
        0: smax = 12'd1;
        1: smax = 12'd4095;
        2: smax = 12'd0;
        3: smax = 12'd255;
        default: smax = LVL_W'($urandom_range(1, 4095));
      endcase
      size = 0;
      used = '0;
      if ($urandom_range(0, 9) >= 4) begin
        size = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                           : $urandom_range(1, TABLE_DEPTH);
        if ($urandom_range(0, 5) == 0) size = TABLE_DEPTH;
        used = USED_W'(size);
        // counts past the table depth saturate
        if (size == TABLE_DEPTH && $urandom_range(0, 1) != 0)
          used = USED_W'($urandom_range(TABLE_DEPTH + 1, 63));
      end
      set_config(ovr, used, smax);
      tx_no_idle = (phase % 4 == 0) || ($urandom_range(0, 4) == 0);
      rx_no_idle = (phase % 4 == 0) || ($urandom_range(0, 4) == 0);

      // fresh table, every entry in use written before any query
      ascending = ($urandom_range(0, 4) != 0);
      lv = $urandom_range(0, 100);
      for (j = 0; j < size; j++) begin
        if (!ascending) lv = $urandom_range(0, 4095);
        send_load(IDX_W'(j), LVL_W'(lv), ALP_W'($urandom));
        step_max = (4095 - lv) / (size - j);
        lv = lv + $urandom_range(1, (step_max > 1) ? step_max : 1);
        if (lv > 4095) lv = 4095;
      end

      goal = n_loads + n_queries + n_scales + PHASE_ITEMS;
      while (n_loads + n_queries + n_scales < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          send_query(pick_level());
          blen = $urandom_range(1, SCALED_CMD_LEN);
          for (p = 0; p < blen; p++)
            send_scale(BYTE_W'($urandom), POS_W'(p), POS_W'(SCALED_CMD_LEN));
        end else if (sel < 90) begin
          send_scale(BYTE_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        end else if (sel < 95) begin
          send_query(LVL_W'($urandom));
        end else if (sel < 98) begin
          send_load(IDX_W'($urandom), LVL_W'($urandom), ALP_W'($urandom));
        end else begin
          send_unused();
        end
      end
      phase++;
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // Result side: random stalls, or one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        stall = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, value %0d clamped %0d",
                 $time, value_o, clamped_o);
        mismatches++;
      end else begin
        exp_result = pending_results.pop_front();
        if (value_o !== exp_result.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d",
                   $time, exp_result.value, value_o);
          mismatches++;
        end
        if (clamped_o !== exp_result.clamped) begin
          $display("%0t: clamped mismatch, expected %0d, got %0d",
                   $time, exp_result.clamped, clamped_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, nothing moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending_results.size());
        $display("tb_brightness_alpha_interpolator NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_table();
    test_override_and_full_scale();
    test_loaded_table();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    $display("Covered %0d table loads, %0d queries, %0d command bytes (%0d forced to zero)",
             n_loads, n_queries, n_scales, n_clamped);
    $display("and %0d ignored items over %0d register settings; %0d results, %0d mismatches",
             n_ignored, n_settings, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_brightness_alpha_interpolator OK");
    end else begin
      $display("tb_brightness_alpha_interpolator NOT OK");
    end
    $finish;
  end

endmodule
